// ===== hdl/bqf_pkg.sv =====
package bqf_pkg;

   localparam int MAX_SECTIONS = 3;
   localparam int SECTIONS     = 3;
   localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

   localparam int SAMPLE_W = 12;
   localparam int SIG_W    = 40;
   localparam int COEF_W   = 20;
   localparam int FRAC_W   = 16;
   localparam int FF_W     = 3 * COEF_W;
   localparam int FB_W     = 2 * COEF_W;
   localparam int PART_W   = COEF_W + 1;
   localparam int MUL_W    = COEF_W + PART_W;
   localparam int PROD_W   = MUL_W + 1;
   localparam int ACC_W    = PROD_W + COEF_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = FF_W;

   localparam int STEP_W    = 4;
   localparam int LAST_STEP = 11;

   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [SEC_W-1:0]      sec_type;
   typedef logic [STEP_W-1:0]     step_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BYPASS  = 3'd0,
      REG_SEC0_FF = 3'd1,
      REG_SEC0_FB = 3'd2,
      REG_SEC1_FF = 3'd3,
      REG_SEC1_FB = 3'd4,
      REG_SEC2_FF = 3'd5,
      REG_SEC2_FB = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic                                bypass;
      logic [MAX_SECTIONS-1:0][FF_W-1:0]   ff;
      logic [MAX_SECTIONS-1:0][FB_W-1:0]   fb;
   } cfg_type;

   typedef enum logic [2:0] {
      COEF_B0,
      COEF_B1,
      COEF_B2,
      COEF_A1,
      COEF_A2
   } coef_sel_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_Y,
      FIN_D1,
      FIN_D2
   } fin_sel_type;

   typedef struct packed {
      logic         load_x;
      logic         load_out;
      logic         mul;
      coef_sel_type coef;
      logic         opnd_y;
      logic         hi;
      logic         neg;
      logic         clr;
      fin_sel_type  fin;
      sec_type      sec;
   } cmd_type;

endpackage

// ===== hdl/bqf_if.sv =====
interface bqf_req_if;
   import bqf_pkg::*;
   logic       valid;
   logic       ready;
   sample_type adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bqf_rsp_if;
   import bqf_pkg::*;
   logic       valid;
   logic       ready;
   sample_type dac_value;
   modport source (output valid, output dac_value, input ready);
   modport sink   (input valid, input dac_value, output ready);
endinterface

interface bqf_csr_if;
   import bqf_pkg::*;
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bqf_csr.sv =====
module bqf_csr (
   input  logic            clock,
   input  logic            reset,
   bqf_csr_if.sink         csr,
   output bqf_pkg::cfg_type cfg
);
   import bqf_pkg::*;

   cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bypass <= 1'b1;
         for (int s = 0; s < MAX_SECTIONS; s++) begin
            cfg_ff.ff[s] <= FF_W'(65536);
            cfg_ff.fb[s] <= '0;
         end
      end else if (csr.valid) begin
         case (csr.index)
            REG_BYPASS:  cfg_ff.bypass <= csr.data[0];
            REG_SEC0_FF: cfg_ff.ff[0]  <= csr.data[FF_W-1:0];
            REG_SEC0_FB: cfg_ff.fb[0]  <= csr.data[FB_W-1:0];
            REG_SEC1_FF: cfg_ff.ff[1]  <= csr.data[FF_W-1:0];
            REG_SEC1_FB: cfg_ff.fb[1]  <= csr.data[FB_W-1:0];
            REG_SEC2_FF: cfg_ff.ff[2]  <= csr.data[FF_W-1:0];
            REG_SEC2_FB: cfg_ff.fb[2]  <= csr.data[FB_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== hdl/bqf_ctrl.sv =====
module bqf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             bypass,
   output bqf_pkg::cmd_type cmd
);
   import bqf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   sec_type   sec_ff, sec_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.sec      = sec_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      sec_in       = sec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_x = 1'b1;
               step_in    = '0;
               sec_in     = '0;
               state_in   = bypass ? ST_HOLD : ST_RUN;
            end
         end
         ST_RUN: begin
            // per section: y, then d1, then d2, one product half per cycle
            case (step_ff)
               4'd0: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_B0; cmd.clr = 1'b1;
               end
               4'd1: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_B0; cmd.hi = 1'b1;
               end
               4'd2: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_B1; cmd.clr = 1'b1;
               end
               4'd3: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_B1; cmd.hi = 1'b1;
                  cmd.fin = FIN_Y;
               end
               4'd4: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_A1; cmd.opnd_y = 1'b1;
                  cmd.neg = 1'b1;
               end
               4'd5: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_A1; cmd.opnd_y = 1'b1;
                  cmd.neg = 1'b1; cmd.hi = 1'b1;
               end
               4'd6: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_B2; cmd.clr = 1'b1;
               end
               4'd7: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_B2; cmd.hi = 1'b1;
                  cmd.fin = FIN_D1;
               end
               4'd8: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_A2; cmd.opnd_y = 1'b1;
                  cmd.neg = 1'b1;
               end
               4'd9: begin
                  cmd.mul = 1'b1; cmd.coef = COEF_A2; cmd.opnd_y = 1'b1;
                  cmd.neg = 1'b1; cmd.hi = 1'b1;
               end
               4'd11: cmd.fin = FIN_D2;
               default: ;
            endcase
            if (step_ff == STEP_W'(LAST_STEP)) begin
               step_in = '0;
               if (sec_ff == SEC_W'(SECTIONS - 1)) begin
                  state_in = ST_HOLD;
               end else begin
                  sec_in = sec_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/bqf_dp.sv =====
module bqf_dp (
   input  logic                clock,
   input  logic                reset,
   input  bqf_pkg::cmd_type    cmd,
   input  bqf_pkg::cfg_type    cfg,
   input  bqf_pkg::sample_type adc_sample,
   output bqf_pkg::sample_type dac_value
);
   import bqf_pkg::*;

   function automatic logic signed [SIG_W-1:0] sat40(input logic signed [SIG_W+6:0] v);
      logic signed [SIG_W+6:0] hi_lim;
      logic signed [SIG_W+6:0] lo_lim;
      hi_lim = (SIG_W+7)'({1'b0, {(SIG_W-1){1'b1}}});
      lo_lim = -hi_lim - 1;
      if (v > hi_lim) begin
         return {1'b0, {(SIG_W-1){1'b1}}};
      end else if (v < lo_lim) begin
         return {1'b1, {(SIG_W-1){1'b0}}};
      end
      return v[SIG_W-1:0];
   endfunction

   logic signed [SIG_W-1:0]  x_ff, x_in;
   logic signed [SIG_W-1:0]  y_ff, y_in;
   logic signed [SIG_W-1:0]  d1_ff [SECTIONS];
   logic signed [SIG_W-1:0]  d2_ff [SECTIONS];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pmul_ff, phi_ff, pclr_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   sample_type               sample_ff;
   sample_type               dac_ff, dac_in;

   logic signed [COEF_W-1:0]  coef;
   logic signed [SIG_W-1:0]   opnd;
   logic signed [PART_W-1:0]  part;
   logic signed [MUL_W-1:0]   mul_res;
   logic signed [PROD_W-1:0]  mul_ext;
   logic signed [ACC_W-1:0]   addend;
   logic signed [SIG_W-1:0]   fin_add;
   logic signed [SIG_W+6:0]   fin_sum;
   logic signed [SIG_W-1:0]   fin_val;
   logic signed [SAMPLE_W:0]  centered;
   logic signed [SIG_W-FRAC_W:0] out_sum;

   assign dac_value = dac_ff;

   always_comb begin
      case (cmd.coef)
         COEF_B0: coef = cfg.ff[cmd.sec][COEF_W-1:0];
         COEF_B1: coef = cfg.ff[cmd.sec][2*COEF_W-1:COEF_W];
         COEF_B2: coef = cfg.ff[cmd.sec][3*COEF_W-1:2*COEF_W];
         COEF_A1: coef = cfg.fb[cmd.sec][COEF_W-1:0];
         COEF_A2: coef = cfg.fb[cmd.sec][2*COEF_W-1:COEF_W];
         default: coef = '0;
      endcase
      opnd    = cmd.opnd_y ? y_ff : x_ff;
      part    = cmd.hi ? {opnd[SIG_W-1], opnd[SIG_W-1:COEF_W]}
                       : {1'b0, opnd[COEF_W-1:0]};
      mul_res = coef * part;
      mul_ext = {mul_res[MUL_W-1], mul_res};
      prod_in = cmd.neg ? -mul_ext : mul_ext;
   end

   always_comb begin
      addend = phi_ff ? {prod_ff, {COEF_W{1'b0}}}
                      : {{COEF_W{prod_ff[PROD_W-1]}}, prod_ff};
      acc_in = acc_ff;
      if (pmul_ff) begin
         acc_in = (pclr_ff ? '0 : acc_ff) + addend;
      end
   end

   always_comb begin
      case (cmd.fin)
         FIN_Y:   fin_add = d1_ff[cmd.sec];
         FIN_D1:  fin_add = d2_ff[cmd.sec];
         default: fin_add = '0;
      endcase
      fin_sum = (SIG_W+7)'($signed(acc_ff[ACC_W-1:FRAC_W]))
              + (SIG_W+7)'(fin_add);
      fin_val = sat40(fin_sum);
   end

   always_comb begin
      centered = $signed({1'b0, adc_sample}) - (SAMPLE_W+1)'(2048);
      x_in     = x_ff;
      if (cmd.load_x) begin
         x_in = {{(SIG_W-FRAC_W-SAMPLE_W-1){centered[SAMPLE_W]}}, centered,
                 {FRAC_W{1'b0}}};
      end else if (cmd.fin == FIN_D2) begin
         x_in = y_ff;
      end
      y_in = (cmd.fin == FIN_Y) ? fin_val : y_ff;
   end

   always_comb begin
      out_sum = $signed({y_ff[SIG_W-1], y_ff[SIG_W-1:FRAC_W]})
              + (SIG_W-FRAC_W+1)'(2048);
      if (cfg.bypass) begin
         dac_in = sample_ff;
      end else if (out_sum < 0) begin
         dac_in = '0;
      end else if (out_sum > (SIG_W-FRAC_W+1)'(4095)) begin
         dac_in = '1;
      end else begin
         dac_in = out_sum[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      phi_ff  <= cmd.hi;
      pclr_ff <= cmd.clr;
      acc_ff  <= acc_in;
      if (cmd.load_x) begin
         sample_ff <= adc_sample;
      end
      if (cmd.load_out) begin
         dac_ff <= dac_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmul_ff <= 1'b0;
         for (int s = 0; s < SECTIONS; s++) begin
            d1_ff[s] <= '0;
            d2_ff[s] <= '0;
         end
      end else begin
         pmul_ff <= cmd.mul;
         if (cmd.fin == FIN_D1) begin
            d1_ff[cmd.sec] <= fin_val;
         end
         if (cmd.fin == FIN_D2) begin
            d2_ff[cmd.sec] <= fin_val;
         end
      end
   end

endmodule

// ===== hdl/cascaded_biquad_iir_filter_core.sv =====
// Cascaded biquad filter for 12-bit converter samples. Each request carries one
// sample (2048 = zero); the response is the filtered value plus 2048, clamped
// to 0..4095, or the sample unchanged while bypass is set. Up to three
// transposed direct form II sections run in Q23.16 with saturating sums and
// signed Q3.16 coefficients (b0/b1/b2 and a1/a2 packed per section). One
// 20x21-bit multiplier is shared by all products: each section runs ten product
// halves and then the final delay update, while a bypassed request skips the
// sections and goes straight to the response register. A new request is taken
// once the previous result sits in the response register. Delay state is held
// during bypass and cleared only by reset. Write registers only while no request
// is in flight.
module cascaded_biquad_iir_filter_core (
   input  logic      clock,
   input  logic      reset,
   bqf_req_if.sink   req,
   bqf_rsp_if.source rsp,
   bqf_csr_if.sink   csr
);
   import bqf_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   bqf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   bqf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .bypass    (cfg.bypass),
      .cmd       (cmd)
   );

   bqf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .adc_sample (req.adc_sample),
      .dac_value  (rsp.dac_value)
   );

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted but controller stayed idle");

   a_load_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp.valid)
      else $error("result loaded without response valid");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_x, cmd.load_out, cmd.mul}))
      else $error("conflicting datapath commands");

   a_d2_no_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.fin == FIN_D2 |-> !cmd.mul && $past(!cmd.mul))
      else $error("delay two update overlaps a pending product");

endmodule
